/* hdl/mcke_pkg.sv */
// Shared types, constants and the Morse pattern table of the keying encoder.
package mcke_pkg;

    localparam int CODE_W   = 8;
    localparam int HZ_W     = 16;
    localparam int DIT_W    = 16;
    localparam int DUR_W    = 18;
    localparam int PAT_SYMS = 6;                 // longest pattern in the table
    localparam int SYM_W    = 2;
    localparam int PLEN_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_TDATA_W = 40;             // 34 payload bits padded to bytes

    localparam logic [CFG_IDX_W-1:0] REG_DIT_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_HZ = 2'd1;

    localparam logic [DIT_W-1:0] DIT_MS_RESET  = 16'd80;
    localparam logic [HZ_W-1:0]  TONE_HZ_RESET = 16'd800;

    typedef enum logic [SYM_W-1:0] {
        SYM_DIT = 2'b00,
        SYM_DAH = 2'b01,
        SYM_GAP = 2'b10
    } t_sym;

    // First symbol in the top two bits of sym.
    typedef struct packed {
        logic [PLEN_W-1:0]         len;
        logic [PAT_SYMS*SYM_W-1:0] sym;
    } t_pattern;

    typedef struct packed {
        logic load;
        logic emit_sym;
        logic emit_gap;
        logic emit_close;
    } t_dp_cmd;

    typedef struct packed {
        logic has_sym;
    } t_dp_stat;

    // Symbol codes: 00 dit, 01 dah, 10 word gap.
    function automatic t_pattern pattern_lookup(input logic [6:0] code);
        t_pattern p;
        p = '0;
        case (code)
            7'd32:  p = {3'd1, 12'b10_00_00_00_00_00};
            7'd33:  p = {3'd6, 12'b00_01_00_01_00_01};
            7'd34:  p = {3'd6, 12'b00_01_00_00_01_00};
            7'd39:  p = {3'd6, 12'b00_01_01_01_01_00};
            7'd40:  p = {3'd6, 12'b01_00_01_01_00_01};
            7'd41:  p = {3'd6, 12'b01_00_01_01_00_01};
            7'd44:  p = {3'd6, 12'b01_01_00_00_01_01};
            7'd45:  p = {3'd6, 12'b01_00_00_00_00_01};
            7'd46:  p = {3'd6, 12'b00_01_00_01_00_01};
            7'd47:  p = {3'd5, 12'b01_00_00_01_00_00};
            7'd48:  p = {3'd5, 12'b01_01_01_01_01_00};
            7'd49:  p = {3'd5, 12'b00_01_01_01_01_00};
            7'd50:  p = {3'd5, 12'b00_00_01_01_01_00};
            7'd51:  p = {3'd5, 12'b00_00_00_01_01_00};
            7'd52:  p = {3'd5, 12'b00_00_00_00_01_00};
            7'd53:  p = {3'd5, 12'b00_00_00_00_00_00};
            7'd54:  p = {3'd5, 12'b01_00_00_00_00_00};
            7'd55:  p = {3'd5, 12'b01_01_00_00_00_00};
            7'd56:  p = {3'd5, 12'b01_01_01_00_00_00};
            7'd57:  p = {3'd5, 12'b01_01_01_01_00_00};
            7'd58:  p = {3'd6, 12'b01_01_01_00_00_00};
            7'd59:  p = {3'd6, 12'b01_00_01_00_01_00};
            7'd61:  p = {3'd5, 12'b01_00_00_00_01_00};
            7'd63:  p = {3'd6, 12'b00_00_01_01_00_00};
            7'd64:  p = {3'd6, 12'b00_01_01_00_01_00};
            7'd65, 7'd97:  p = {3'd2, 12'b00_01_00_00_00_00};
            7'd66, 7'd98:  p = {3'd4, 12'b01_00_00_00_00_00};
            7'd67, 7'd99:  p = {3'd4, 12'b01_00_01_00_00_00};
            7'd68, 7'd100: p = {3'd3, 12'b01_00_00_00_00_00};
            7'd69, 7'd101: p = {3'd1, 12'b00_00_00_00_00_00};
            7'd70, 7'd102: p = {3'd4, 12'b00_00_01_00_00_00};
            7'd71, 7'd103: p = {3'd3, 12'b01_01_00_00_00_00};
            7'd72, 7'd104: p = {3'd4, 12'b00_00_00_00_00_00};
            7'd73, 7'd105: p = {3'd2, 12'b00_00_00_00_00_00};
            7'd74, 7'd106: p = {3'd4, 12'b00_01_01_01_00_00};
            7'd75, 7'd107: p = {3'd3, 12'b01_00_01_00_00_00};
            7'd76, 7'd108: p = {3'd4, 12'b00_01_00_00_00_00};
            7'd77, 7'd109: p = {3'd2, 12'b01_01_00_00_00_00};
            7'd78, 7'd110: p = {3'd2, 12'b01_00_00_00_00_00};
            7'd79, 7'd111: p = {3'd3, 12'b01_01_01_00_00_00};
            7'd80, 7'd112: p = {3'd4, 12'b00_01_01_00_00_00};
            7'd81, 7'd113: p = {3'd4, 12'b01_01_00_01_00_00};
            7'd82, 7'd114: p = {3'd3, 12'b00_01_00_00_00_00};
            7'd83, 7'd115: p = {3'd3, 12'b00_00_00_00_00_00};
            7'd84, 7'd116: p = {3'd1, 12'b01_00_00_00_00_00};
            7'd85, 7'd117: p = {3'd3, 12'b00_00_01_00_00_00};
            7'd86, 7'd118: p = {3'd4, 12'b00_00_00_01_00_00};
            7'd87, 7'd119: p = {3'd3, 12'b00_01_01_00_00_00};
            7'd88, 7'd120: p = {3'd4, 12'b01_00_00_01_00_00};
            7'd89, 7'd121: p = {3'd4, 12'b01_00_01_01_00_00};
            7'd90, 7'd122: p = {3'd4, 12'b01_01_00_00_00_00};
            7'd91, 7'd93, 7'd123, 7'd125:
                    p = {3'd6, 12'b01_00_01_01_00_01};
            7'd92, 7'd126:
                    p = {3'd5, 12'b01_00_00_01_00_00};
            7'd95:  p = {3'd6, 12'b00_00_01_01_00_01};
            7'd96:  p = {3'd6, 12'b00_01_01_01_01_00};
            7'd127: p = {3'd5, 12'b00_10_00_10_00_00};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* hdl/mcke_dp.sv */
// Datapath of the keying encoder: registers, pattern shifter and segment output register.
module mcke_dp
    import mcke_pkg::*;
#(
    parameter int MAX_SYMBOLS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [CODE_W-1:0]    i_code,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [HZ_W-1:0]      o_hz,
    output logic [DUR_W-1:0]     o_dur,
    output logic                 o_last
);

    logic [DIT_W-1:0]          r_dit_ms;
    logic [HZ_W-1:0]           r_tone_hz;
    logic [PAT_SYMS*SYM_W-1:0] r_sym;
    logic [PLEN_W-1:0]         r_cnt;
    logic [HZ_W-1:0]           r_hz;
    logic [DUR_W-1:0]          r_dur;
    logic                      r_last;

    t_pattern          w_pat;
    logic [PLEN_W-1:0] w_len;
    logic [DUR_W-1:0]  w_dur1, w_dur2, w_dur3;
    t_sym              w_head;

    assign w_pat  = pattern_lookup(i_code[6:0]);
    assign w_len  = (int'(w_pat.len) > MAX_SYMBOLS) ? PLEN_W'(MAX_SYMBOLS) : w_pat.len;
    assign w_dur1 = DUR_W'(r_dit_ms);
    assign w_dur2 = {1'b0, r_dit_ms, 1'b0};
    assign w_dur3 = w_dur1 + w_dur2;
    assign w_head = t_sym'(r_sym[PAT_SYMS*SYM_W-1 -: SYM_W]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_ms  <= DIT_MS_RESET;
            r_tone_hz <= TONE_HZ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIT_MS:  r_dit_ms  <= i_cfg_data;
                REG_TONE_HZ: r_tone_hz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pattern shifter: take the head symbol, shift the rest up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= w_len;
        end else if (i_cmd.emit_sym) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= w_pat.sym;
        end else if (i_cmd.emit_sym) begin
            r_sym <= r_sym << SYM_W;
        end
    end

    // Segment output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sym) begin
            r_last <= 1'b0;
            case (w_head)
                SYM_DIT: begin
                    r_hz  <= r_tone_hz;
                    r_dur <= w_dur1;
                end
                SYM_DAH: begin
                    r_hz  <= r_tone_hz;
                    r_dur <= w_dur3;
                end
                default: begin
                    r_hz  <= '0;
                    r_dur <= w_dur2;
                end
            endcase
        end else if (i_cmd.emit_gap) begin
            r_hz   <= '0;
            r_dur  <= w_dur1;
            r_last <= 1'b0;
        end else if (i_cmd.emit_close) begin
            r_hz   <= '0;
            r_dur  <= w_dur2;
            r_last <= 1'b1;
        end
    end

    assign o_stat.has_sym = (r_cnt != '0);
    assign o_hz   = r_hz;
    assign o_dur  = r_dur;
    assign o_last = r_last;

endmodule

/* hdl/mcke_ctrl.sv */
// Controller of the keying encoder: sequences symbol, gap and closing segments.
module mcke_ctrl
    import mcke_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_code_high,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SYM,
        S_GAP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;
    logic   w_emit;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_code_high) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SYM;
                end
            end
            S_SYM: begin
                if (w_slot_free) begin
                    if (i_stat.has_sym) begin
                        o_cmd.emit_sym = 1'b1;
                        n_state        = S_GAP;
                    end else begin
                        o_cmd.emit_close = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_GAP: begin
                if (w_slot_free) begin
                    o_cmd.emit_gap = 1'b1;
                    n_state        = S_SYM;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_emit = o_cmd.emit_sym || o_cmd.emit_gap || o_cmd.emit_close;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.emit_sym, o_cmd.emit_gap, o_cmd.emit_close}))
        else $error("controller issued more than one command");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_emit)
        else $error("segment register overwritten while stalled");

    a_load_then_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SYM) && !o_in_ready)
        else $error("load did not start a pattern");

    a_close_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_close |=> r_out_valid && (r_state == S_IDLE))
        else $error("closing pause did not end the run");

endmodule

/* hdl/morse_code_keying_encoder.sv */
// Top level of the Morse keying encoder: stream ports, config port, controller and datapath.
//
// Usage:
//   Slave stream (i_s_*): one item is one character byte. Codes 128 and up are
//   taken and dropped without any result. Every other code yields a run of
//   keying segments on the master stream (o_m_*): for each pattern symbol a
//   tone or silence segment and a one-dit silence, then a two-dit closing
//   silence flagged by o_m_tlast.
//   Config port (i_cfg_*): index 0 writes dit_ms, index 1 tone_hz, other
//   indices are ignored. o_cfg_ready is always high; write only while idle.
//   Timing: the pattern is loaded first, then one segment per cycle while
//   the receiver takes them; the slave side stays busy until the closing
//   segment is issued. A dropped high code is taken in the idle state.
//   The closing segment waits in the output register while the next
//   character is already accepted.
//   Stall: with o_m_tready low the output register holds its segment and the
//   controller holds its place in the pattern.
//   Reset (synchronous, active low): output empty, dit_ms = 80, tone_hz = 800.
module morse_code_keying_encoder
    import mcke_pkg::*;
#(
    parameter int MAX_SYMBOLS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [CODE_W-1:0]      i_s_tdata,    // [7:0] char_code
    // master stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,    // [15:0] segment_hz, [33:16] duration_ms, rest 0
    output logic                   o_m_tlast,    // last
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [HZ_W-1:0]  w_hz;
    logic [DUR_W-1:0] w_dur;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    mcke_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_code_high (i_s_tdata[CODE_W-1]),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (w_cmd)
    );

    mcke_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_code      (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_hz        (w_hz),
        .o_dur       (w_dur),
        .o_last      (o_m_tlast)
    );

    // Pack the segment, padding to whole bytes
    assign o_m_tdata = {{(OUT_TDATA_W - DUR_W - HZ_W){1'b0}}, w_dur, w_hz};

endmodule
